// ===== sv/bpps_pkg.sv =====
package bpps_pkg;

  localparam int unsigned MAX_CAND = 32;
  localparam int unsigned MAX_INC  = 32;
  localparam int unsigned DIST_W   = 24;
  localparam int unsigned ID_W     = 16;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned CIDX_W = (MAX_CAND > 1) ? $clog2(MAX_CAND) : 1;
  localparam int unsigned CCNT_W = $clog2(MAX_CAND + 1);
  localparam int unsigned IIDX_W = (MAX_INC > 1) ? $clog2(MAX_INC) : 1;
  localparam int unsigned ICNT_W = $clog2(MAX_INC + 1);
  // budget sums and position compares
  localparam int unsigned SUM_W  = CFG_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_CAND = 2'd0,
    CMD_LOAD_INC  = 2'd1,
    CMD_SELECT    = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_PROMOTE = 2'd0,
    KIND_DEMOTE  = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREE_BUDGET    = 2'd0,
    CFG_MAX_PREEMPTS   = 2'd1,
    CFG_PREEMPT_MARGIN = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RD_I      = 2'd0,
    RD_J      = 2'd1,
    RD_CURSOR = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    load_cand;
    logic    load_inc;
    logic    sel_init;
    logic    pass_start;
    logic    scan_step;
    logic    pass_end;
    logic    promote;
    logic    wscan_start;
    logic    wscan_step;
    logic    demote;
    logic    finish;
    rd_sel_e rd_sel;
  } ctrl_t;

  typedef struct packed {
    logic sort_more;
    logic scan_more;
    logic promote_more;
    logic preempt_more;
    logic wscan_more;
    logic found;
    logic beats;
    logic out_free;
  } status_t;

endpackage

// ===== sv/bpps_if.sv =====
interface bpps_in_if;
  import bpps_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [ID_W-1:0]     entry_id;
  logic                entry_in_view;
  logic [DIST_W-1:0]   entry_distance;

  modport source (output valid, cmd, entry_id, entry_in_view, entry_distance,
                  input ready);
  modport sink   (input valid, cmd, entry_id, entry_in_view, entry_distance,
                  output ready);
endinterface

interface bpps_out_if;
  import bpps_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   result_id;
  logic              last;

  modport source (output valid, kind, result_id, last, input ready);
  modport sink   (input valid, kind, result_id, last, output ready);
endinterface

// ===== sv/budgeted_promote_preempt_select_unit.sv =====
// channel   dir  beat payload                                   accepted when
// in_chan   in   cmd, entry_id, entry_in_view, entry_distance    valid & ready
// out_chan  out  kind, result_id, last                           valid & ready
// cfg       in   cfg_idx_i, cfg_data_i                           cfg_we_i
//
// loads are taken only while idle; a load to a full list is dropped
// a select holds ready low until its end marker is issued; one compare unit walks the
// candidate list per ranked place and the incumbent list per challenge
// reset clears the counts, taken flags, configuration and loop registers; stores need no clearing pass
// a stalled out_chan holds the next result beat and the walk behind it
module budgeted_promote_preempt_select_unit
  import bpps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bpps_in_if.sink               in_chan,
  bpps_out_if.source            out_chan,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_t   ctrl;
  status_t sts;

  bpps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_cmd_i   (in_chan.cmd),
    .in_ready_o (in_chan.ready),
    .sts_i      (sts),
    .cmd_o      (ctrl)
  );

  bpps_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl),
    .sts_o       (sts),
    .in_id_i     (in_chan.entry_id),
    .in_view_i   (in_chan.entry_in_view),
    .in_dist_i   (in_chan.entry_distance),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_chan.ready),
    .out_valid_o (out_chan.valid),
    .out_kind_o  (out_chan.kind),
    .out_id_o    (out_chan.result_id),
    .out_last_o  (out_chan.last)
  );

endmodule

// ===== sv/bpps_ctrl.sv =====
module bpps_ctrl
  import bpps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  output logic             in_ready_o,
  input  status_t          sts_i,
  output ctrl_t            cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_SCAN,
    ST_PROMOTE,
    ST_PREEMPT,
    ST_WSCAN,
    ST_DECIDE,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_CURSOR;
    state_d      = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_cmd_i)
            CMD_LOAD_CAND: cmd_o.load_cand = 1'b1;
            CMD_LOAD_INC:  cmd_o.load_inc  = 1'b1;
            CMD_SELECT: begin
              cmd_o.sel_init = 1'b1;
              state_d        = ST_PASS;
            end
            default: ;
          endcase
        end
      end
      ST_PASS: begin
        cmd_o.rd_sel = RD_I;
        if (sts_i.sort_more) begin
          cmd_o.pass_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_PROMOTE;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_sel = RD_J;
        if (sts_i.scan_more) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          cmd_o.pass_end = 1'b1;
          state_d        = ST_PASS;
        end
      end
      ST_PROMOTE: begin
        if (!sts_i.promote_more) begin
          state_d = ST_PREEMPT;
        end else if (sts_i.out_free) begin
          cmd_o.promote = 1'b1;
        end
      end
      ST_PREEMPT: begin
        if (sts_i.preempt_more) begin
          cmd_o.wscan_start = 1'b1;
          state_d           = ST_WSCAN;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_WSCAN: begin
        if (sts_i.wscan_more) begin
          cmd_o.wscan_step = 1'b1;
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!(sts_i.found && sts_i.beats)) begin
          state_d = ST_FINISH;
        end else if (sts_i.out_free) begin
          cmd_o.demote = 1'b1;
          state_d      = ST_PREEMPT;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/bpps_datapath.sv =====
module bpps_datapath
  import bpps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 cmd_i,
  output status_t               sts_o,
  input  logic [ID_W-1:0]       in_id_i,
  input  logic                  in_view_i,
  input  logic [DIST_W-1:0]     in_dist_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [KIND_W-1:0]     out_kind_o,
  output logic [ID_W-1:0]       out_id_o,
  output logic                  out_last_o
);

  // stores
  logic [ID_W-1:0]   cand_id_q   [MAX_CAND];
  logic              cand_view_q [MAX_CAND];
  logic [DIST_W-1:0] cand_dist_q [MAX_CAND];
  logic [ID_W-1:0]   inc_id_q    [MAX_INC];
  logic              inc_view_q  [MAX_INC];
  logic [DIST_W-1:0] inc_dist_q  [MAX_INC];
  logic [CIDX_W-1:0] rank_q      [MAX_CAND];
  logic [MAX_INC-1:0] taken_mask_q;

  logic [CCNT_W-1:0] cand_cnt_q;
  logic [ICNT_W-1:0] inc_cnt_q;

  // configuration
  logic [CFG_W-1:0]  budget_q;
  logic [CFG_W-1:0]  preempts_q;
  logic [DIST_W-1:0] margin_q;

  // loop state
  logic [CCNT_W-1:0] sorted_q;
  logic [CCNT_W-1:0] i_q;
  logic [CCNT_W-1:0] j_q;
  logic [CCNT_W-1:0] cursor_q;
  logic [CCNT_W-1:0] taken_q;
  logic [ICNT_W-1:0] k_q;
  logic              found_q;

  // running best candidate of a pass
  logic [CIDX_W-1:0] best_pos_q;
  logic [CIDX_W-1:0] best_rank_q;
  logic [CIDX_W-1:0] i_rank_q;
  logic              best_view_q;
  logic [DIST_W-1:0] best_dist_q;

  // running worst incumbent
  logic [IIDX_W-1:0] w_idx_q;
  logic [ID_W-1:0]   w_id_q;
  logic              w_view_q;
  logic [DIST_W-1:0] w_dist_q;

  logic              out_valid_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [ID_W-1:0]   out_id_q;
  logic              out_last_q;

  logic [CCNT_W-1:0] ridx;
  logic [CIDX_W-1:0] rank_rd;
  logic [ID_W-1:0]   rd_id;
  logic              rd_view;
  logic [DIST_W-1:0] rd_dist;
  logic [IIDX_W-1:0] k_idx;
  logic              k_view;
  logic [DIST_W-1:0] k_dist;
  logic              k_worse;
  logic              j_better;
  logic [SUM_W-1:0]  place_sum;
  logic [CCNT_W-1:0] sorted_d;
  logic [DIST_W:0]   lead_sum;
  logic              out_free;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_I:      ridx = i_q;
      RD_J:      ridx = j_q;
      RD_CURSOR: ridx = cursor_q;
      default:   ridx = cursor_q;
    endcase
  end

  assign rank_rd = rank_q[ridx[CIDX_W-1:0]];
  assign rd_id   = cand_id_q[rank_rd];
  assign rd_view = cand_view_q[rank_rd];
  assign rd_dist = cand_dist_q[rank_rd];

  assign k_idx  = k_q[IIDX_W-1:0];
  assign k_view = inc_view_q[k_idx];
  assign k_dist = inc_dist_q[k_idx];

  assign j_better = (rd_view != best_view_q) ? rd_view : (rd_dist < best_dist_q);
  assign k_worse  = (k_view != w_view_q) ? !k_view : (k_dist > w_dist_q);

  assign place_sum = SUM_W'(budget_q) + SUM_W'(preempts_q);
  assign sorted_d  = (place_sum > SUM_W'(cand_cnt_q)) ? cand_cnt_q : CCNT_W'(place_sum);

  // exact sum, one spare bit so nothing wraps
  assign lead_sum = {1'b0, rd_dist} + {1'b0, margin_q};

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o              = '0;
    sts_o.sort_more    = (i_q < sorted_q);
    sts_o.scan_more    = (j_q < cand_cnt_q);
    sts_o.promote_more = (cursor_q < sorted_q) && (SUM_W'(cursor_q) < SUM_W'(budget_q));
    sts_o.preempt_more = (cursor_q < sorted_q) && (SUM_W'(taken_q) < SUM_W'(preempts_q));
    sts_o.wscan_more   = (k_q < inc_cnt_q);
    sts_o.found        = found_q;
    sts_o.beats        = (rd_view && !w_view_q) ||
                         ((rd_view == w_view_q) && (lead_sum < {1'b0, w_dist_q}));
    sts_o.out_free     = out_free;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_cnt_q   <= '0;
      inc_cnt_q    <= '0;
      taken_mask_q <= '0;
      budget_q     <= '0;
      preempts_q   <= '0;
      margin_q     <= '0;
      sorted_q     <= '0;
      i_q          <= '0;
      j_q          <= '0;
      cursor_q     <= '0;
      taken_q      <= '0;
      k_q          <= '0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FREE_BUDGET:    budget_q   <= cfg_data_i[CFG_W-1:0];
          CFG_MAX_PREEMPTS:   preempts_q <= cfg_data_i[CFG_W-1:0];
          CFG_PREEMPT_MARGIN: margin_q   <= cfg_data_i[DIST_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load_cand && (cand_cnt_q < CCNT_W'(MAX_CAND))) begin
        cand_cnt_q <= cand_cnt_q + CCNT_W'(1);
      end
      if (cmd_i.load_inc && (inc_cnt_q < ICNT_W'(MAX_INC))) begin
        inc_cnt_q <= inc_cnt_q + ICNT_W'(1);
      end
      if (cmd_i.sel_init) begin
        sorted_q <= sorted_d;
        i_q      <= '0;
        cursor_q <= '0;
        taken_q  <= '0;
      end
      if (cmd_i.pass_start) begin
        j_q <= i_q + CCNT_W'(1);
      end
      if (cmd_i.scan_step) begin
        j_q <= j_q + CCNT_W'(1);
      end
      if (cmd_i.pass_end) begin
        i_q <= i_q + CCNT_W'(1);
      end
      if (cmd_i.promote) begin
        cursor_q <= cursor_q + CCNT_W'(1);
      end
      if (cmd_i.wscan_start) begin
        k_q     <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.wscan_step) begin
        k_q <= k_q + ICNT_W'(1);
        if (!taken_mask_q[k_idx] && (!found_q || k_worse)) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.demote) begin
        taken_mask_q[w_idx_q] <= 1'b1;
        taken_q               <= taken_q + CCNT_W'(1);
        cursor_q              <= cursor_q + CCNT_W'(1);
      end
      if (cmd_i.promote || cmd_i.demote || cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        cand_cnt_q   <= '0;
        inc_cnt_q    <= '0;
        taken_mask_q <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cand && (cand_cnt_q < CCNT_W'(MAX_CAND))) begin
      cand_id_q[cand_cnt_q[CIDX_W-1:0]]   <= in_id_i;
      cand_view_q[cand_cnt_q[CIDX_W-1:0]] <= in_view_i;
      cand_dist_q[cand_cnt_q[CIDX_W-1:0]] <= in_dist_i;
    end
    if (cmd_i.load_inc && (inc_cnt_q < ICNT_W'(MAX_INC))) begin
      inc_id_q[inc_cnt_q[IIDX_W-1:0]]   <= in_id_i;
      inc_view_q[inc_cnt_q[IIDX_W-1:0]] <= in_view_i;
      inc_dist_q[inc_cnt_q[IIDX_W-1:0]] <= in_dist_i;
    end
    if (cmd_i.sel_init) begin
      for (int unsigned p = 0; p < MAX_CAND; p++) begin
        rank_q[p] <= CIDX_W'(p);
      end
    end else if (cmd_i.pass_end && (best_pos_q != i_q[CIDX_W-1:0])) begin
      rank_q[i_q[CIDX_W-1:0]] <= best_rank_q;
      rank_q[best_pos_q]      <= i_rank_q;
    end
    if (cmd_i.pass_start) begin
      best_pos_q  <= i_q[CIDX_W-1:0];
      best_rank_q <= rank_rd;
      i_rank_q    <= rank_rd;
      best_view_q <= rd_view;
      best_dist_q <= rd_dist;
    end
    if (cmd_i.scan_step && j_better) begin
      best_pos_q  <= j_q[CIDX_W-1:0];
      best_rank_q <= rank_rd;
      best_view_q <= rd_view;
      best_dist_q <= rd_dist;
    end
    // strict compare keeps the earliest loaded on a tie
    if (cmd_i.wscan_step && !taken_mask_q[k_idx] && (!found_q || k_worse)) begin
      w_idx_q  <= k_idx;
      w_id_q   <= inc_id_q[k_idx];
      w_view_q <= k_view;
      w_dist_q <= k_dist;
    end
    if (cmd_i.promote) begin
      out_kind_q <= KIND_PROMOTE;
      out_id_q   <= rd_id;
      out_last_q <= 1'b0;
    end else if (cmd_i.demote) begin
      out_kind_q <= KIND_DEMOTE;
      out_id_q   <= w_id_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_kind_q <= KIND_END;
      out_id_q   <= '0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_id_o    = out_id_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== test/budgeted_promote_preempt_select_unit_tb.sv =====
`timescale 1ns / 100ps

module budgeted_promote_preempt_select_unit_tb;
  import bpps_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS  = 380;

  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0] id;
    logic            last;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bpps_in_if  in_chan ();
  bpps_out_if out_chan ();

  budgeted_promote_preempt_select_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow copy of the lists and registers
  logic [ID_W-1:0]   cand_id_mem   [MAX_CAND];
  logic              cand_vis_mem  [MAX_CAND];
  logic [DIST_W-1:0] cand_dist_mem [MAX_CAND];
  int unsigned       n_cand;
  logic [ID_W-1:0]   inc_id_mem    [MAX_INC];
  logic              inc_vis_mem   [MAX_INC];
  logic [DIST_W-1:0] inc_dist_mem  [MAX_INC];
  int unsigned       n_inc;
  logic [5:0]        budget_q;
  logic [5:0]        preempts_q;
  logic [DIST_W-1:0] margin_q;

  outcome_t    outcome_q [$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit cand_ahead(int unsigned a, int unsigned b);
    if (cand_vis_mem[a] != cand_vis_mem[b]) return cand_vis_mem[a];
    return cand_dist_mem[a] < cand_dist_mem[b];
  endfunction

  function automatic bit inc_weaker(int unsigned a, int unsigned b);
    if (inc_vis_mem[a] != inc_vis_mem[b]) return !inc_vis_mem[a];
    return inc_dist_mem[a] > inc_dist_mem[b];
  endfunction

  function automatic void note_outcome(kind_e kind, logic [ID_W-1:0] id, logic last);
    outcome_t o;
    o.kind = kind;
    o.id   = id;
    o.last = last;
    outcome_q.push_back(o);
  endfunction

  // partial selection sort, promotes, then challenges against the worst incumbent
  function automatic void rank_and_preempt();
    int unsigned order [MAX_CAND];
    bit          taken [MAX_INC];
    int unsigned places, pos, best, tmp, worst, spent, c;
    bit          found, wins;
    logic [DIST_W:0] reach;
    for (int k = 0; k < MAX_INC; k++) taken[k] = 1'b0;
    for (int k = 0; k < n_cand; k++) order[k] = k;
    places = budget_q + preempts_q;
    if (places > n_cand) places = n_cand;
    for (int p = 0; p < places; p++) begin
      best = p;
      for (int q = p + 1; q < n_cand; q++)
        if (cand_ahead(order[q], order[best])) best = q;
      tmp         = order[p];
      order[p]    = order[best];
      order[best] = tmp;
    end
    pos = 0;
    while (pos < places && pos < budget_q) begin
      note_outcome(KIND_PROMOTE, cand_id_mem[order[pos]], 1'b0);
      pos++;
    end
    spent = 0;
    while (pos < places && spent < preempts_q) begin
      found = 1'b0;
      worst = 0;
      for (int k = 0; k < n_inc; k++)
        if (!taken[k] && (!found || inc_weaker(k, worst))) begin
          worst = k;
          found = 1'b1;
        end
      if (!found) break;
      c     = order[pos];
      reach = {1'b0, cand_dist_mem[c]} + {1'b0, margin_q};
      wins  = (cand_vis_mem[c] && !inc_vis_mem[worst]) ||
              (cand_vis_mem[c] == inc_vis_mem[worst] && reach < {1'b0, inc_dist_mem[worst]});
      if (!wins) break;
      note_outcome(KIND_DEMOTE, inc_id_mem[worst], 1'b0);
      taken[worst] = 1'b1;
      spent++;
      pos++;
    end
    note_outcome(KIND_END, '0, 1'b1);
    n_cand = 0;
    n_inc  = 0;
  endfunction

  function automatic void absorb_entry(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                       logic vis, logic [DIST_W-1:0] distance);
    case (cmd)
      CMD_LOAD_CAND: if (n_cand < MAX_CAND) begin
        cand_id_mem[n_cand]   = id;
        cand_vis_mem[n_cand]  = vis;
        cand_dist_mem[n_cand] = distance;
        n_cand++;
      end
      CMD_LOAD_INC: if (n_inc < MAX_INC) begin
        inc_id_mem[n_inc]   = id;
        inc_vis_mem[n_inc]  = vis;
        inc_dist_mem[n_inc] = distance;
        n_inc++;
      end
      CMD_SELECT: rank_and_preempt();
      default: ;
    endcase
  endfunction

  // predict on every input beat, check every output beat
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (in_chan.valid && in_chan.ready)
        absorb_entry(in_chan.cmd, in_chan.entry_id, in_chan.entry_in_view,
                     in_chan.entry_distance);
      if (out_chan.valid && out_chan.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d id %h last %b", $time,
                   out_chan.kind, out_chan.result_id, out_chan.last);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          if (out_chan.kind !== want.kind || out_chan.result_id !== want.id ||
              out_chan.last !== want.last) begin
            $display("%0t: expected kind %0d id %h last %b, got kind %0d id %h last %b",
                     $time, want.kind, want.id, want.last,
                     out_chan.kind, out_chan.result_id, out_chan.last);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("budgeted_promote_preempt_select_unit_tb: FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls, or a long hold-off when asked
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_entry(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, logic vis,
                            logic [DIST_W-1:0] distance);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_chan.valid          <= 1'b1;
    in_chan.cmd            <= cmd;
    in_chan.entry_id       <= id;
    in_chan.entry_in_view  <= vis;
    in_chan.entry_distance <= distance;
    do @(posedge clk_i); while (in_chan.ready !== 1'b1);
  endtask

  task automatic settle_block();
    in_chan.valid <= 1'b0;
    do @(negedge clk_i); while (outcome_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [5:0] budget, logic [5:0] preempts,
                                logic [DIST_W-1:0] margin);
    settle_block();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FREE_BUDGET;
    cfg_data_i <= CFG_DATA_W'(budget);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_PREEMPTS;
    cfg_data_i <= CFG_DATA_W'(preempts);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PREEMPT_MARGIN;
    cfg_data_i <= CFG_DATA_W'(margin);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    budget_q   = budget;
    preempts_q = preempts;
    margin_q   = margin;
  endtask

  function automatic logic [DIST_W-1:0] rand_distance();
    case ($urandom_range(2))
      0:       return DIST_W'($urandom);
      1:       return DIST_W'($urandom_range(255));
      default: return {DIST_W{1'b1}} - DIST_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [5:0] rand_count();
    case ($urandom_range(3))
      0:       return 6'd0;
      1:       return 6'd63;
      2:       return 6'd32;
      default: return 6'($urandom_range(8));
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] rand_margin();
    case ($urandom_range(3))
      0:       return '0;
      1:       return {DIST_W{1'b1}};
      2:       return DIST_W'($urandom_range(64));
      default: return DIST_W'($urandom);
    endcase
  endfunction

  // reset values: nothing ranked, only the end marker
  task automatic test_empty_select();
    send_entry(CMD_SELECT, 16'hFFFF, 1'b1, {DIST_W{1'b1}});
    settle_block();
  endtask

  // view first, nearer next, ties as the swap sort leaves them, unused command dropped
  task automatic test_ranking_ties();
    apply_settings(6'd2, 6'd3, '0);
    send_entry(CMD_LOAD_CAND, 16'h0000, 1'b0, 24'h000010);
    send_entry(CMD_LOAD_CAND, 16'hFFFF, 1'b1, 24'hFFFFFF);
    send_entry(CMD_LOAD_CAND, 16'h1234, 1'b1, 24'h000100);
    send_entry(CMD_LOAD_INC,  16'h8001, 1'b0, 24'hFFFFFF);
    send_entry(CMD_LOAD_CAND, 16'h0BAD, 1'b1, 24'h000100);
    send_entry(CMD_LOAD_CAND, 16'h5A5A, 1'b0, 24'h000000);
    send_entry(CMD_LOAD_INC,  16'h8002, 1'b1, 24'h000200);
    send_entry(CMD_UNUSED,    16'hDEAD, 1'b1, 24'h000001);
    send_entry(CMD_LOAD_CAND, 16'hA5A5, 1'b0, 24'h000010);
    send_entry(CMD_LOAD_INC,  16'h8003, 1'b0, 24'hFFFFFF);
    send_entry(CMD_SELECT,    16'h0000, 1'b0, '0);
    settle_block();
  endtask

  // in view beats out of view at any margin; the sum does not wrap; a tie loses
  task automatic test_margin_extremes();
    apply_settings(6'd0, 6'd2, {DIST_W{1'b1}});
    send_entry(CMD_LOAD_CAND, 16'h0001, 1'b0, 24'h000000);
    send_entry(CMD_LOAD_CAND, 16'h0002, 1'b1, 24'hFFFFFF);
    send_entry(CMD_LOAD_INC,  16'h0101, 1'b0, 24'hFFFFFF);
    send_entry(CMD_LOAD_INC,  16'h0102, 1'b0, 24'hFFFFFE);
    send_entry(CMD_SELECT,    16'h0000, 1'b0, '0);
    apply_settings(6'd0, 6'd1, '0);
    send_entry(CMD_LOAD_CAND, 16'h0003, 1'b1, 24'h000005);
    send_entry(CMD_LOAD_INC,  16'h0103, 1'b1, 24'h000005);
    send_entry(CMD_SELECT,    16'h0000, 1'b0, '0);
    settle_block();
  endtask

  // budgets past the candidate count
  task automatic test_large_budgets();
    apply_settings(6'd63, 6'd63, 24'h000100);
    send_entry(CMD_LOAD_CAND, 16'h0201, 1'b0, 24'h000300);
    send_entry(CMD_LOAD_CAND, 16'h0202, 1'b1, 24'h000300);
    send_entry(CMD_LOAD_INC,  16'h0301, 1'b0, 24'h800000);
    send_entry(CMD_SELECT,    16'h0000, 1'b0, '0);
    settle_block();
  endtask

  // both lists overfilled; extra loads must vanish
  task automatic test_store_full();
    apply_settings(6'd16, 6'd63, 24'h000040);
    for (int k = 0; k < MAX_CAND + 2; k++) begin
      send_entry(CMD_LOAD_CAND, ID_W'($urandom), 1'b1, rand_distance());
      send_entry(CMD_LOAD_INC, ID_W'($urandom), ($urandom_range(3) == 0), rand_distance());
    end
    send_entry(CMD_SELECT, ID_W'($urandom), 1'b0, '0);
    settle_block();
  endtask

  // long result stall with the sender still pushing, then a full pause
  task automatic test_backpressure();
    apply_settings(6'd4, 6'd4, 24'h000010);
    hold_left = HOLD_CYCLES;
    for (int k = 0; k < 8; k++)
      send_entry(CMD_LOAD_CAND, ID_W'($urandom), 1'($urandom), rand_distance());
    for (int k = 0; k < 4; k++)
      send_entry(CMD_LOAD_INC, ID_W'($urandom), 1'($urandom), rand_distance());
    send_entry(CMD_SELECT, 16'h0000, 1'b0, '0);
    for (int k = 0; k < 5; k++)
      send_entry(CMD_LOAD_CAND, ID_W'($urandom), 1'($urandom), rand_distance());
    for (int k = 0; k < 3; k++)
      send_entry(CMD_LOAD_INC, ID_W'($urandom), 1'($urandom), rand_distance());
    send_entry(CMD_SELECT, 16'h0000, 1'b0, '0);
    settle_block();
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned sent, seq_no, n_c, n_i;
    sent   = 0;
    seq_no = 0;
    while (sent < n_items) begin
      if (sent < n_items / 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 63;
      end else if (sent < 2 * n_items / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seq_no % 4 == 0) apply_settings(rand_count(), rand_count(), rand_margin());
      n_c = ($urandom_range(11) == 0) ? $urandom_range(28, 36) : $urandom_range(10);
      n_i = ($urandom_range(11) == 0) ? $urandom_range(28, 36) : $urandom_range(10);
      while (n_c + n_i > 0) begin
        if ($urandom_range(9) == 0) begin
          send_entry(CMD_UNUSED, ID_W'($urandom), 1'($urandom), DIST_W'($urandom));
          sent++;
        end
        if ($urandom_range(n_c + n_i - 1) < n_c) begin
          send_entry(CMD_LOAD_CAND, ID_W'($urandom), 1'($urandom), rand_distance());
          n_c--;
        end else begin
          send_entry(CMD_LOAD_INC, ID_W'($urandom), 1'($urandom), rand_distance());
          n_i--;
        end
        sent++;
      end
      // now and then the select is left out and the lists keep growing
      if ($urandom_range(9) != 0) begin
        send_entry(CMD_SELECT, ID_W'($urandom), 1'($urandom), DIST_W'($urandom));
        sent++;
      end
      seq_no++;
    end
    send_entry(CMD_SELECT, ID_W'($urandom), 1'($urandom), DIST_W'($urandom));
    settle_block();
  endtask

  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CFG_FREE_BUDGET;
    cfg_data_i             = '0;
    in_chan.valid          = 1'b0;
    in_chan.cmd            = CMD_LOAD_CAND;
    in_chan.entry_id       = '0;
    in_chan.entry_in_view  = 1'b0;
    in_chan.entry_distance = '0;
    n_cand        = 0;
    n_inc         = 0;
    budget_q      = '0;
    preempts_q    = '0;
    margin_q      = '0;
    fail_count    = 0;
    quiet_cycles  = 0;
    hold_left     = 0;
    send_idle_pct = 36;
    recv_idle_pct = 63;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_select();
    test_ranking_ties();
    test_margin_extremes();
    test_large_budgets();
    test_store_full();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    if (fail_count == 0 && outcome_q.size() == 0) begin
      $display("budgeted_promote_preempt_select_unit_tb: PASS");
    end else begin
      $display("budgeted_promote_preempt_select_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
